FILE: hdl/sms_pkg.sv
package sms_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 8;
  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int DIM_W      = 4;
  localparam int CNT_W      = 7;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLS);

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [CNT_W-1:0] total;
  } walk_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } walk_pos_t;

endpackage

FILE: hdl/sms_ram.sv
module sms_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/sms_walk.sv
module sms_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  sms_pkg::walk_cfg_t            cfg,
  input  logic                          issue,
  output logic                          busy,
  output sms_pkg::walk_pos_t            pos,
  output logic [sms_pkg::ADDR_W-1:0]    addr
);

  sms_pkg::dir_t                   dir_r, dir_nxt;
  logic [sms_pkg::ROW_W-1:0]       row_r, row_nxt, top_r, top_nxt, bot_r, bot_nxt;
  logic [sms_pkg::COL_W-1:0]       col_r, col_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;
  logic [sms_pkg::CNT_W-1:0]       rem_r, rem_nxt;
  logic [sms_pkg::DIM_W-1:0]       cols_r, cols_nxt;
  logic [sms_pkg::CNT_W-1:0]       prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= sms_pkg::DIR_RIGHT;
      rem_r <= '0;
    end else begin
      dir_r <= dir_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    top_r  <= top_nxt;
    bot_r  <= bot_nxt;
    lft_r  <= lft_nxt;
    rgt_r  <= rgt_nxt;
    cols_r <= cols_nxt;
  end

  always_comb begin
    dir_nxt  = dir_r;
    rem_nxt  = rem_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    top_nxt  = top_r;
    bot_nxt  = bot_r;
    lft_nxt  = lft_r;
    rgt_nxt  = rgt_r;
    cols_nxt = cols_r;
    if (start) begin
      dir_nxt  = sms_pkg::DIR_RIGHT;
      rem_nxt  = cfg.total;
      row_nxt  = '0;
      col_nxt  = '0;
      top_nxt  = '0;
      lft_nxt  = '0;
      bot_nxt  = sms_pkg::ROW_W'(cfg.rows - 1'b1);
      rgt_nxt  = sms_pkg::COL_W'(cfg.cols - 1'b1);
      cols_nxt = cfg.cols;
    end else if (issue && busy) begin
      rem_nxt = rem_r - 1'b1;
      case (dir_r)
        sms_pkg::DIR_RIGHT: begin
          if (col_r != rgt_r) begin
            col_nxt = col_r + 1'b1;
          end else begin
            top_nxt = top_r + 1'b1;
            row_nxt = row_r + 1'b1;
            dir_nxt = sms_pkg::DIR_DOWN;
          end
        end
        sms_pkg::DIR_DOWN: begin
          if (row_r != bot_r) begin
            row_nxt = row_r + 1'b1;
          end else begin
            rgt_nxt = rgt_r - 1'b1;
            col_nxt = col_r - 1'b1;
            dir_nxt = sms_pkg::DIR_LEFT;
          end
        end
        sms_pkg::DIR_LEFT: begin
          if (col_r != lft_r) begin
            col_nxt = col_r - 1'b1;
          end else begin
            bot_nxt = bot_r - 1'b1;
            row_nxt = row_r - 1'b1;
            dir_nxt = sms_pkg::DIR_UP;
          end
        end
        sms_pkg::DIR_UP: begin
          if (row_r != top_r) begin
            row_nxt = row_r - 1'b1;
          end else begin
            lft_nxt = lft_r + 1'b1;
            col_nxt = col_r + 1'b1;
            dir_nxt = sms_pkg::DIR_RIGHT;
          end
        end
        default: begin
          dir_nxt = sms_pkg::DIR_RIGHT;
        end
      endcase
    end
  end

  assign busy     = (rem_r != '0);
  assign pos.row  = row_r;
  assign pos.col  = col_r;
  assign pos.last = (rem_r == sms_pkg::CNT_W'(1));
  assign prod     = sms_pkg::CNT_W'(row_r) * sms_pkg::CNT_W'(cols_r);
  assign addr     = sms_pkg::ADDR_W'(prod + sms_pkg::CNT_W'(col_r));

endmodule

FILE: hdl/spiral_order_matrix_scan_top.sv
// Spiral-order matrix scanner.
// The input channel (in_valid, in_ready, in_element_value) takes one matrix
// element per item in row-major order, at most one per cycle. Registers
// row_count (index 0) and col_count (index 1) are written through the cfg_
// channel, which is always ready; values above 8 act as 8, and a zero
// dimension makes the block drop input items without any result.
// When the item that completes the rows x cols matrix is accepted, in_ready
// goes low and the stored elements are read back in clockwise spiral order,
// one memory read per cycle. The first result passes through the walk
// registers, the memory read register and the output register, and results
// then follow one per cycle while out_ready is high. Each result carries the
// element, its row and column, and out_last_of_run on the final one.
// A stall on the output holds the current result; a skid register absorbs the
// read already in flight, and the walk pauses until space frees up.
// in_ready returns as soon as the last read has been issued.
// Synchronous reset clears the load count, the walk and the output stage and
// sets both dimensions to 8. The element memory is not cleared.
module spiral_order_matrix_scan_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sms_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sms_pkg::DATA_W-1:0] out_value,
  output logic [sms_pkg::ROW_W-1:0]         out_row,
  output logic [sms_pkg::COL_W-1:0]         out_col,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sms_pkg::DIM_W-1:0]         cfg_data
);

  logic [sms_pkg::DIM_W-1:0]  row_count_r, col_count_r;
  logic [sms_pkg::DIM_W-1:0]  rows_eff, cols_eff;
  logic [sms_pkg::CNT_W-1:0]  load_count_r, load_count_nxt, load_inc;
  sms_pkg::walk_cfg_t         wcfg;
  sms_pkg::walk_pos_t         wpos, rd_pos_r, sk_pos_r;
  logic [sms_pkg::ADDR_W-1:0] raddr;
  logic [sms_pkg::DATA_W-1:0] rdata, sk_value_r;
  logic                       walk_busy, in_fire, dims_ok, wr_en, start;
  logic                       issue, rd_vld_r, sk_vld_r, out_vld_r, out_take, out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= sms_pkg::ROWS_MAX;
      col_count_r <= sms_pkg::COLS_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sms_pkg::REG_ROW_COUNT: row_count_r <= cfg_data;
        sms_pkg::REG_COL_COUNT: col_count_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign rows_eff   = (row_count_r > sms_pkg::ROWS_MAX) ? sms_pkg::ROWS_MAX : row_count_r;
  assign cols_eff   = (col_count_r > sms_pkg::COLS_MAX) ? sms_pkg::COLS_MAX : col_count_r;
  assign wcfg.rows  = rows_eff;
  assign wcfg.cols  = cols_eff;
  assign wcfg.total = sms_pkg::CNT_W'(rows_eff) * sms_pkg::CNT_W'(cols_eff);

  assign in_ready = !walk_busy;
  assign in_fire  = in_valid && in_ready;
  assign dims_ok  = (rows_eff != '0) && (cols_eff != '0);
  assign wr_en    = in_fire && dims_ok;
  assign load_inc = load_count_r + 1'b1;
  assign start    = wr_en && (load_inc >= wcfg.total);

  always_comb begin
    load_count_nxt = load_count_r;
    if (wr_en) begin
      load_count_nxt = start ? '0 : load_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
    end
  end

  sms_ram #(
    .DEPTH  (sms_pkg::DEPTH),
    .ADDR_W (sms_pkg::ADDR_W),
    .DATA_W (sms_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (load_count_r[sms_pkg::ADDR_W-1:0]),
    .wdata (in_element_value),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  sms_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cfg   (wcfg),
    .issue (issue),
    .busy  (walk_busy),
    .pos   (wpos),
    .addr  (raddr)
  );

  assign out_take = out_vld_r && out_ready;
  assign out_free = !out_vld_r || out_ready;
  assign issue    = walk_busy && !sk_vld_r && !(rd_vld_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      sk_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (sk_vld_r) begin
        if (out_free) begin
          sk_vld_r  <= 1'b0;
          out_vld_r <= 1'b1;
        end
      end else if (rd_vld_r) begin
        if (out_free) begin
          out_vld_r <= 1'b1;
        end else begin
          sk_vld_r <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_pos_r <= wpos;
    end
    if (sk_vld_r) begin
      if (out_free) begin
        out_value       <= sk_value_r;
        out_row         <= sk_pos_r.row;
        out_col         <= sk_pos_r.col;
        out_last_of_run <= sk_pos_r.last;
      end
    end else if (rd_vld_r) begin
      if (out_free) begin
        out_value       <= rdata;
        out_row         <= rd_pos_r.row;
        out_col         <= rd_pos_r.col;
        out_last_of_run <= rd_pos_r.last;
      end else begin
        sk_value_r <= rdata;
        sk_pos_r   <= rd_pos_r;
      end
    end
  end

  assign out_valid = out_vld_r;

endmodule

FILE: hdl/sms_chk.sv
module sms_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sms_pkg::DATA_W-1:0] out_value,
  input logic [sms_pkg::ROW_W-1:0]         out_row,
  input logic [sms_pkg::COL_W-1:0]         out_col,
  input logic                              out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_row) &&
      $stable(out_col) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input closed without a completing item");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready, 2))
    else $error("result appeared without a spiral walk");

endmodule

bind spiral_order_matrix_scan_top sms_chk u_sms_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value       (out_value),
  .out_row         (out_row),
  .out_col         (out_col),
  .out_last_of_run (out_last_of_run)
);
